// ===== rtl/core/sfsl_pkg.sv =====
// Shared types and constants for the sorted free-space list.
// No dependencies; imported by the core, the sequencer and the testbench.
package sfsl_pkg;

  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 32;
  localparam int HELD_W   = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REM_WAIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] got_offset;
    logic [SIZE_W-1:0]   got_size;
    logic [HELD_W-1:0]   entries_held;
  } result_t;

endpackage

// ===== rtl/core/sorted_free_space_list_core.sv =====
// Sorted free-space list, largest first. Throughput is one request at a time, set
// by the single RAM write port moving one entry per cycle. Reset is synchronous
// and empties the list at once.
module sorted_free_space_list_core #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [sfsl_pkg::OFFSET_W-1:0] space_offset,
  input  logic [sfsl_pkg::SIZE_W-1:0]   space_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [sfsl_pkg::OFFSET_W-1:0] got_offset,
  output logic [sfsl_pkg::SIZE_W-1:0]   got_size,
  output logic [sfsl_pkg::HELD_W-1:0]   entries_held
);
  import sfsl_pkg::*;

  logic    res_valid, res_take;
  result_t res, out_reg;

  sfsl_seq #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .space_offset(space_offset),
    .space_size  (space_size),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // The output register takes a new result whenever it is empty or draining.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      out_reg <= res;
    end
  end

  assign status       = out_reg.status;
  assign got_offset   = out_reg.got_offset;
  assign got_size     = out_reg.got_size;
  assign entries_held = out_reg.entries_held;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer accepted a request without going busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> entries_held == HELD_W'(LIST_DEPTH))
    else $error("full status with a list that is not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |->
      entries_held == '0 && got_offset == '0 && got_size == '0)
    else $error("empty status with data or a nonzero count");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result dropped or changed");
`endif

endmodule

// ===== rtl/core/sfsl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the free-space entry store.
module sfsl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sfsl_seq.sv =====
// Sequencer for the sorted free-space list: circular entry store in RAM,
// insert by walking from the tail and shifting smaller entries down one place.
// Depends on sfsl_pkg and sfsl_ram.
module sfsl_seq #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [sfsl_pkg::OFFSET_W-1:0] space_offset,
  input  logic [sfsl_pkg::SIZE_W-1:0]   space_size,
  output logic                          res_valid,
  input  logic                          res_take,
  output sfsl_pkg::result_t             res
);
  import sfsl_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  state_t          state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   idx, idx_next;
  entry_t          new_entry, new_entry_next;
  status_t         res_status, res_status_next;
  entry_t          got, got_next;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;
  logic [CW-1:0]   count_m1;

  // Logical position to physical RAM address, relative to the head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] lg);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, lg};
    if (s >= (AW+1)'(LIST_DEPTH)) begin
      s = s - (AW+1)'(LIST_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  sfsl_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign count_m1 = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    idx        <= idx_next;
    new_entry  <= new_entry_next;
    res_status <= res_status_next;
    got        <= got_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    new_entry_next  = new_entry;
    res_status_next = res_status;
    got_next        = got;
    we              = 1'b0;
    waddr           = phys(head, idx);
    wdata           = new_entry;
    raddr           = head;
    in_stall        = (state != ST_IDLE);
    res_valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          new_entry_next  = '{size: space_size, offset: space_offset};
          got_next        = '0;
          res_status_next = STAT_DONE;
          if (opcode == OP_INSERT) begin
            if (count == CW'(LIST_DEPTH)) begin
              res_status_next = STAT_FULL;
              state_next      = ST_RESP;
            end else if (count == '0) begin
              we         = 1'b1;
              waddr      = head;
              wdata      = '{size: space_size, offset: space_offset};
              count_next = count + CW'(1);
              state_next = ST_RESP;
            end else begin
              // Start the walk at the tail.
              raddr      = phys(head, count_m1[AW-1:0]);
              idx_next   = count[AW-1:0];
              state_next = ST_INS_CMP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = ST_RESP;
            end else begin
              raddr      = head;
              state_next = ST_REM_WAIT;
            end
          end
        end
      end

      ST_INS_CMP: begin
        we    = 1'b1;
        waddr = phys(head, idx);
        if (rdata.size < new_entry.size) begin
          // Move the smaller entry down and fetch the next one up.
          wdata = rdata;
          if (idx == AW'(1)) begin
            idx_next   = '0;
            state_next = ST_INS_PUT;
          end else begin
            raddr    = phys(head, idx - AW'(2));
            idx_next = idx - AW'(1);
          end
        end else begin
          wdata      = new_entry;
          count_next = count + CW'(1);
          state_next = ST_RESP;
        end
      end

      ST_INS_PUT: begin
        we         = 1'b1;
        waddr      = phys(head, idx);
        wdata      = new_entry;
        count_next = count + CW'(1);
        state_next = ST_RESP;
      end

      ST_REM_WAIT: begin
        got_next   = rdata;
        head_next  = (head == AW'(LIST_DEPTH - 1)) ? '0 : head + AW'(1);
        count_next = count - CW'(1);
        state_next = ST_RESP;
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res.status       = res_status;
    res.got_offset   = got.offset;
    res.got_size     = got.size;
    res.entries_held = HELD_W'(count);
  end

endmodule

// ===== sim/sorted_free_space_list_core_test.sv =====
// Self-checking testbench for the sorted free-space list core.
// Depends on sfsl_pkg and sorted_free_space_list_core; predicts every response
// from its own largest-first list and compares each result field.
`timescale 1ns / 100ps

module sorted_free_space_list_core_test;
  import sfsl_pkg::*;

  localparam int DEPTH       = 64;
  localparam int LONG_HOLD   = 500;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic                op;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
  } space_req_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                opcode       = OP_INSERT;
  logic [OFFSET_W-1:0] space_offset = '0;
  logic [SIZE_W-1:0]   space_size   = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [1:0]          status;
  logic [OFFSET_W-1:0] got_offset;
  logic [SIZE_W-1:0]   got_size;
  logic [HELD_W-1:0]   entries_held;

  // Expected list contents, position 0 is the largest space.
  logic [SIZE_W-1:0]   list_sizes   [DEPTH];
  logic [OFFSET_W-1:0] list_offsets [DEPTH];
  int                  list_count = 0;

  space_req_t pending_reqs[$];
  result_t    awaited_results[$];

  bit req_taken      = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int full_count     = 0;
  int empty_count    = 0;
  int peak_held      = 0;

  sorted_free_space_list_core #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .space_offset(space_offset),
    .space_size  (space_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .got_offset  (got_offset),
    .got_size    (got_size),
    .entries_held(entries_held)
  );

  always #1 clk = ~clk;

  // Applies one request to the expected list and returns the response it causes.
  function automatic result_t apply_space_request(input space_req_t r);
    result_t res;
    int      pos;
    int      i;
    res.status     = STAT_DONE;
    res.got_offset = '0;
    res.got_size   = '0;
    if (r.op == OP_INSERT) begin
      if (list_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        // Equal sizes stay in arrival order, so skip past every size >= new one.
        pos = 0;
        while (pos < list_count && list_sizes[pos] >= r.size) pos++;
        for (i = list_count; i > pos; i--) begin
          list_sizes[i]   = list_sizes[i-1];
          list_offsets[i] = list_offsets[i-1];
        end
        list_sizes[pos]   = r.size;
        list_offsets[pos] = r.offset;
        list_count++;
      end
    end else begin
      if (list_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.got_offset = list_offsets[0];
        res.got_size   = list_sizes[0];
        for (i = 1; i < list_count; i++) begin
          list_sizes[i-1]   = list_sizes[i];
          list_offsets[i-1] = list_offsets[i];
        end
        list_count--;
      end
    end
    res.entries_held = list_count[HELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
             cycle_count, what, seen, wanted);
    error_count++;
  endtask

  task automatic queue_request(input logic op, input logic [OFFSET_W-1:0] off,
                               input logic [SIZE_W-1:0] sz);
    space_req_t r;
    r.op     = op;
    r.offset = off;
    r.size   = sz;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return SIZE_W'($urandom);
      1: return SIZE_W'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? {SIZE_W{1'b1}} : '0;
      default: return SIZE_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {OFFSET_W{1'b1}};
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || awaited_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // Random traffic in runs that lean toward filling or toward emptying the list.
  task automatic run_phase(input int n, input int send_pct, input int stall_pct);
    int left;
    int run_len;
    int ins_pct;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    left    = n;
    ins_pct = 85;
    while (left > 0) begin
      run_len = $urandom_range(30, 120);
      while (run_len > 0 && left > 0) begin
        queue_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                      pick_offset(), pick_size());
        run_len--;
        left--;
      end
      ins_pct = (ins_pct == 85) ? 20 : 85;
    end
    wait_drain();
  endtask

  // Request driver: a new request is offered only once the current one is taken.
  always @(negedge clk) begin
    space_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        opcode       <= nxt.op;
        space_offset <= nxt.offset;
        space_size   <= nxt.size;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall, with a long hold-off counted here when one is requested.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: checks accepted results, then predicts for accepted requests.
  always @(posedge clk) begin
    result_t    want;
    space_req_t taken;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(status), 64'(0));
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
          if (got_offset !== want.got_offset)
            report_mismatch("got_offset", 64'(got_offset), 64'(want.got_offset));
          if (got_size !== want.got_size)
            report_mismatch("got_size", 64'(got_size), 64'(want.got_size));
          if (entries_held !== want.entries_held)
            report_mismatch("entries_held", 64'(entries_held), 64'(want.entries_held));
          if (want.status == STAT_FULL) full_count++;
          if (want.status == STAT_EMPTY) empty_count++;
          if (int'(want.entries_held) > peak_held) peak_held = int'(want.entries_held);
        end
      end
      if (in_valid && !in_stall) begin
        taken.op     = opcode;
        taken.offset = space_offset;
        taken.size   = space_size;
        awaited_results.push_back(apply_space_request(taken));
        req_taken = 1'b1;
        accepted_count++;
      end
    end
  end

  initial begin
    int i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty remove, field extremes, ties kept in arrival order.
    queue_request(OP_REMOVE, '1, '1);
    queue_request(OP_INSERT, '0, '0);
    queue_request(OP_REMOVE, '0, '0);
    queue_request(OP_INSERT, '1, '1);
    queue_request(OP_INSERT, 32'h10, 16'h0100);
    queue_request(OP_INSERT, 32'h20, 16'h0100);
    queue_request(OP_INSERT, 32'h30, 16'h0100);
    queue_request(OP_INSERT, 32'h40, 16'h0000);
    queue_request(OP_INSERT, 32'h50, 16'hFFFF);
    queue_request(OP_INSERT, 32'hAAAA_AAAA, 16'h5555);
    queue_request(OP_INSERT, 32'h5555_5555, 16'hAAAA);
    for (i = 0; i < 9; i++) queue_request(OP_REMOVE, pick_offset(), pick_size());

    // Fill to the limit, push past it, then drain past empty.
    for (i = 0; i < DEPTH + 2; i++) queue_request(OP_INSERT, pick_offset(), pick_size());
    for (i = 0; i < DEPTH + 2; i++) queue_request(OP_REMOVE, pick_offset(), pick_size());
    wait_drain();

    run_phase(250, 0, 0);
    run_phase(250, 78, 0);
    run_phase(250, 0, 78);
    run_phase(250, 28, 28);

    // Results held off for a long stretch while requests keep coming.
    hold_token++;
    run_phase(100, 0, 0);

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d requests and checked %0d results over %0d cycles.",
             accepted_count, result_count, cycle_count);
    $display("Saw %0d inserts rejected as full, %0d removes on empty, peak of %0d spaces.",
             full_count, empty_count, peak_held);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results still awaited",
               error_count, awaited_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sorted_free_space_list_core.f =====
rtl/core/sfsl_pkg.sv
rtl/core/sfsl_ram.sv
rtl/core/sfsl_seq.sv
rtl/core/sorted_free_space_list_core.sv
sim/sorted_free_space_list_core_test.sv
